@@ design/ntc_pkg.sv @@
// shared types and constants for the ntc thermostat
package ntc_pkg;

	localparam int LOG_FRAC   = 24;
	localparam int TEMP_W     = 19;
	localparam int SUM_W      = 24;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd150000;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd27315;
	localparam logic [14:0] KELVIN_OFFSET = 15'd27315;

	// beta * 100 * 2^24 / 29815 split as beta * BQ_HI + (beta * BQ_LO + BQ_ROUND) / 29815,
	// the small quotient taken by a reciprocal multiply, exact for operands below 2^24
	localparam logic [15:0] BQ_HI    = 16'd56271;
	localparam logic [10:0] BQ_LO    = 11'd1735;
	localparam logic [14:0] BQ_ROUND = 15'd14907;
	localparam logic [24:0] BQ_RECIP = 25'd18438901;
	localparam int          BQ_SHIFT = 39;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BETA     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND     = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQUARE,
		ST_NEXT_LOG,
		ST_LN,
		ST_BQ_DIV,
		ST_DEN,
		ST_TK_DIV,
		ST_TEMP,
		ST_MEAN_DIV,
		ST_LEVEL,
		ST_OUT
	} ntc_state_t;

endpackage

@@ design/ntc_stream_if.sv @@
// valid/ready channel carrying one payload item
interface ntc_stream_if #(
	parameter int W = 12
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/ntc_thermostat.sv @@
// ntc thermometer with hysteresis thermostat, iterative datapath
//
// Channels: sample takes adc_sample items (12 bits); result gives {temperature, drive_level}
// once every SAMPLES samples, other items give no result. cfg_we/cfg_idx/cfg_data write
// beta (0), setpoint (1), band (2); user must write only while no item is in work (not enforced).
// Datapath: one 31x31 squaring step builds each log2 (24 passes, two logs per item), small
// constant-reciprocal multiplies give the Beta term and the mean, and one restoring divider,
// a bit per cycle over 48 quotient bits, gives the Kelvin quotient.
// Flow: a zero or full-scale sample, or zero beta, skips the logs and the divide, and a
// non-positive denominator skips the divide. The last item of a group then passes through
// the mean, level and output states, where its result is registered.
// The input is not ready while an item is in work.
// Stalls: the result sits in an output register and the next item is accepted while it waits;
// the block stalls in its output state only if a new result is due before the old one is taken.
// Reset: beta 3950, setpoint 4000, band 200, count and sum zero, level low.
module ntc_thermostat #(
	parameter int SAMPLES        = 10,
	parameter int ADC_FULL_SCALE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [18:0] cfg_data,
	ntc_stream_if.sink   sample,
	ntc_stream_if.source result
);
	import ntc_pkg::*;

	localparam int CNT_W = $clog2(SAMPLES + 1);
	localparam int DIV_W = 48;
	localparam int DIV_CW = 6;
	localparam logic [16:0] FS = 17'(ADC_FULL_SCALE);
	// mean by reciprocal multiply, exact for magnitudes below 2^24
	localparam int     MEAN_SHIFT = 28;
	localparam longint MEAN_RECIP = ((longint'(1) << MEAN_SHIFT) + SAMPLES - 1) / SAMPLES;
	localparam logic [DIV_W-1:0] TK_LIMIT = DIV_W'(TEMP_MAX) + DIV_W'(KELVIN_OFFSET);

	// configuration registers
	logic [12:0]              beta_q;
	logic signed [TEMP_W-1:0] setpoint_q;
	logic [13:0]              band_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q     <= 13'd3950;
			setpoint_q <= 19'sd4000;
			band_q     <= 14'd200;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BETA:     beta_q     <= cfg_data[12:0];
				REG_SETPOINT: setpoint_q <= cfg_data;
				REG_BAND:     band_q     <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	ntc_state_t state_q, state_d;

	logic [11:0]       adc_q;
	logic              second_q;      // second log operand in work
	logic [30:0]       m_q;
	logic [4:0]        e_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [4:0]        it_q;
	logic signed [30:0] l2_q;         // first log, then difference
	logic signed [31:0] lnr_q;
	logic [47:0]       num_q;
	logic [29:0]       bqh_q;
	logic [23:0]       bqx_q;
	logic [29:0]       bq_q;
	// restoring divider for the Kelvin quotient
	logic [DIV_W-1:0]  dq_q;          // dividend shifting into quotient
	logic [DIV_W-1:0]  dr_q;          // remainder
	logic [DIV_W-1:0]  dd_q;          // divisor
	logic [DIV_CW-1:0] dc_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic              neg_q;
	logic [SUM_W-1:0]  mag_q;
	logic [TEMP_W-2:0] mmag_q;
	logic              level_q;
	logic              out_v_q;
	logic signed [TEMP_W-1:0] out_t_q;
	logic              out_l_q;

	// combinational helpers
	logic [16:0] log_v;
	logic [4:0]  top_e;
	logic [61:0] sq;
	logic [31:0] sq_t;
	logic [DIV_W:0] rem_sh;
	logic        rem_ge;
	logic [60:0] lnmag;
	logic [30:0] l2_abs;
	logic [48:0] bq_prod;
	logic signed [33:0] den_v;
	logic [DIV_W-1:0] tk_v;
	logic signed [SUM_W-1:0] sum_v;
	logic [SUM_W-1:0] sum_abs;
	logic [52:0] mean_prod;
	logic signed [TEMP_W+1:0] lo_v, hi_v;
	logic signed [TEMP_W-1:0] mean_v;

	assign log_v = second_q ? 17'(adc_q) : (FS - 17'(adc_q));

	// priority encoder for the top set bit, highest index wins
	always_comb begin
		top_e = '0;
		for (int i = 0; i < 17; i++) begin
			if (log_v[i]) top_e = 5'(i);
		end
	end

	// mantissa stays in [1,2) in Q30, so 31 bits suffice
	assign sq   = 62'(m_q) * 62'(m_q);
	assign sq_t = sq[61:30];

	assign rem_sh = {dr_q, dq_q[DIV_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dd_q};
	assign tk_v   = {dq_q[DIV_W-2:0], rem_ge};

	assign l2_abs = l2_q[30] ? 31'(-l2_q) : 31'(l2_q);
	assign lnmag  = 61'(l2_abs) * 61'(LN2_Q30);

	assign bq_prod = 49'(bqx_q) * 49'(BQ_RECIP);
	assign den_v   = signed'({4'b0, bq_q}) + 34'(lnr_q);

	assign sum_v     = sum_q + SUM_W'(temp_q);
	assign sum_abs   = sum_v[SUM_W-1] ? SUM_W'(-sum_v) : SUM_W'(sum_v);
	assign mean_prod = 53'(mag_q) * 53'(29'(MEAN_RECIP));

	assign lo_v = (TEMP_W+2)'(setpoint_q) - (TEMP_W+2)'(signed'({1'b0, band_q}));
	assign hi_v = (TEMP_W+2)'(setpoint_q) + (TEMP_W+2)'(signed'({1'b0, band_q}));
	assign mean_v = neg_q ? -signed'({1'b0, mmag_q}) : signed'({1'b0, mmag_q});

	assign sample.ready = (state_q == ST_IDLE);
	assign result.valid = out_v_q;
	assign result.data  = {out_t_q, out_l_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample.valid) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (adc_q == '0 || 17'(adc_q) >= FS || beta_q == '0) state_d = ST_TEMP;
				else state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				if (it_q == 5'(LOG_FRAC - 1)) state_d = ST_NEXT_LOG;
			end
			ST_NEXT_LOG: state_d = second_q ? ST_LN : ST_NORM;
			ST_LN:       state_d = ST_BQ_DIV;
			ST_BQ_DIV:   state_d = ST_DEN;
			ST_DEN:      state_d = (den_v <= 0) ? ST_TEMP : ST_TK_DIV;
			ST_TK_DIV: begin
				if (dc_q == 6'(DIV_W - 1)) state_d = ST_TEMP;
			end
			ST_TEMP: begin
				if (cnt_q == CNT_W'(SAMPLES - 1)) state_d = ST_MEAN_DIV;
				else state_d = ST_IDLE;
			end
			ST_MEAN_DIV: state_d = ST_LEVEL;
			ST_LEVEL:    state_d = ST_OUT;
			ST_OUT: begin
				if (!out_v_q || result.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sum_q    <= '0;
			level_q  <= 1'b0;
			out_v_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (out_v_q && result.ready && state_q != ST_OUT) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					adc_q    <= sample.data;
					second_q <= 1'b0;
				end
				ST_NORM: begin
					e_q    <= top_e;
					m_q    <= 31'(log_v) << (5'd30 - top_e);
					frac_q <= '0;
					it_q   <= '0;
					// full scale wins over zero beta
					if (adc_q == '0 || (17'(adc_q) < FS && beta_q == '0)) temp_q <= TEMP_MIN;
					else temp_q <= TEMP_MAX;
				end
				ST_SQUARE: begin
					it_q <= it_q + 5'd1;
					if (sq_t[31]) begin
						m_q    <= 31'(sq_t >> 1);
						frac_q <= {frac_q[LOG_FRAC-2:0], 1'b1};
					end else begin
						m_q    <= 31'(sq_t);
						frac_q <= {frac_q[LOG_FRAC-2:0], 1'b0};
					end
				end
				ST_NEXT_LOG: begin
					if (second_q) l2_q <= l2_q - signed'({2'b0, e_q, frac_q});
					else          l2_q <= signed'({2'b0, e_q, frac_q});
					second_q <= 1'b1;
				end
				ST_LN: begin
					lnr_q <= l2_q[30] ? -signed'(32'((lnmag + 61'd536870912) >> 30))
					                  :  signed'(32'((lnmag + 61'd536870912) >> 30));
					num_q <= (48'(beta_q) * 48'd100) << LOG_FRAC;
					bqh_q <= 30'(beta_q) * 30'(BQ_HI);
					bqx_q <= 24'(beta_q) * 24'(BQ_LO) + 24'(BQ_ROUND);
				end
				// beta term by reciprocal multiply
				ST_BQ_DIV: begin
					bq_q <= bqh_q + 30'(bq_prod >> BQ_SHIFT);
				end
				ST_DEN: begin
					dq_q   <= num_q + 48'(den_v >>> 1);
					dd_q   <= 48'(den_v);
					dr_q   <= '0;
					dc_q   <= '0;
					temp_q <= TEMP_MAX;
				end
				ST_TK_DIV: begin
					dc_q <= dc_q + 6'd1;
					dq_q <= tk_v;
					dr_q <= rem_ge ? DIV_W'(rem_sh - {1'b0, dd_q}) : DIV_W'(rem_sh);
					// kelvin quotient to celsius, saturated
					if (dc_q == 6'(DIV_W - 1)) begin
						if (tk_v > TK_LIMIT) temp_q <= TEMP_MAX;
						else temp_q <= signed'(TEMP_W'(tk_v - DIV_W'(KELVIN_OFFSET)));
					end
				end
				ST_TEMP: begin
					if (cnt_q == CNT_W'(SAMPLES - 1)) begin
						neg_q <= sum_v[SUM_W-1];
						mag_q <= sum_abs + SUM_W'(SAMPLES / 2);
						cnt_q <= '0;
						sum_q <= '0;
					end else begin
						sum_q <= sum_v;
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				// mean magnitude by reciprocal multiply
				ST_MEAN_DIV: begin
					mmag_q <= (TEMP_W-1)'(mean_prod >> MEAN_SHIFT);
				end
				ST_LEVEL: begin
					temp_q <= mean_v;
					if ((TEMP_W+2)'(mean_v) <= lo_v || ((TEMP_W+2)'(mean_v) < hi_v && !level_q))
						level_q <= 1'b0;
					else
						level_q <= 1'b1;
				end
				ST_OUT: begin
					if (!out_v_q || result.ready) begin
						out_v_q <= 1'b1;
						out_t_q <= temp_q;
						out_l_q <= level_q;
					end
				end
				default: ;
			endcase
		end
	end

	// result registered only when the output is free
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !result.ready |=> out_v_q && $stable(out_t_q))
		else $error("result changed while stalled");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(SAMPLES))
		else $error("sample count out of range");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("accepted an item while busy");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the ntc thermostat: random samples, configs and handshakes
`timescale 1ns / 100ps

module testbench;
	import ntc_pkg::*;

	localparam int GROUP      = 10;
	localparam int FULL_SCALE = 4096;
	localparam int SETTLE     = 400;
	localparam int STALL_MAX  = 6000;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic                     level;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [18:0] cfg_data;

	ntc_stream_if #(.W(12)) smp_if ();
	ntc_stream_if #(.W(20)) res_if ();

	ntc_thermostat u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.sample  (smp_if.sink),
		.result  (res_if.source)
	);

	// mirror of the block state and registers
	int unsigned beta_q;
	int          setpoint_q;
	int unsigned band_q;
	int unsigned count_q;
	int          sum_q;
	logic        level_q;

	logic [11:0] adc_queue[$];
	reading_t    reading_queue[$];
	int          idle_pct;
	int          mismatches;
	int          readings_seen;
	int          samples_sent;
	int          stall_cycles;
	bit          settling;

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// log2 in Q24 by repeated squaring
	function automatic longint unsigned log2_q24(int unsigned v);
		int unsigned       e;
		longint unsigned   m;
		longint unsigned   frac;
		e = 0;
		frac = 0;
		while (e < 31 && (v >> (e + 1)) != 0)
			e++;
		m = longint'(v) << (30 - e);
		for (int i = 0; i < LOG_FRAC; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(e) << LOG_FRAC) | frac;
	endfunction

	// one sample to 0.01 C by the beta equation
	function automatic int adc_to_centi(int unsigned adc, int unsigned b);
		longint          l2, lnr, bq, den, tk;
		longint unsigned mag, num;
		if (adc == 0)
			return -27315;
		if (adc >= FULL_SCALE)
			return 150000;
		if (b == 0)
			return -27315;
		l2 = longint'(log2_q24(FULL_SCALE - adc)) - longint'(log2_q24(adc));
		mag = (l2 < 0) ? -l2 : l2;
		mag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
		lnr = (l2 < 0) ? -longint'(mag) : longint'(mag);
		num = (longint'(b) * 100) << LOG_FRAC;
		bq = (num + 14907) / 29815;
		den = bq + lnr;
		if (den <= 0)
			return 150000;
		tk = (num + longint'(den) / 2) / den;
		if (tk > 150000 + 27315)
			return 150000;
		return int'(tk - 27315);
	endfunction

	// accumulate one sample, queue a reading at the end of a group
	function automatic void absorb_sample(logic [11:0] adc);
		int       mean;
		reading_t r;
		sum_q += adc_to_centi(adc, beta_q);
		count_q++;
		if (count_q < GROUP)
			return;
		if (sum_q >= 0)
			mean = (sum_q + GROUP / 2) / GROUP;
		else
			mean = -((-sum_q + GROUP / 2) / GROUP);
		count_q = 0;
		sum_q = 0;
		if (mean <= setpoint_q - int'(band_q) || (mean < setpoint_q + int'(band_q) && !level_q))
			level_q = 1'b0;
		else
			level_q = 1'b1;
		r.temp = mean[TEMP_W-1:0];
		r.level = level_q;
		reading_queue.push_back(r);
	endfunction

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_if.valid <= 1'b0;
		end else begin
			if (smp_if.valid && smp_if.ready) begin
				absorb_sample(smp_if.data);
				samples_sent++;
			end
			if (!smp_if.valid || smp_if.ready) begin
				if (adc_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
					smp_if.valid <= 1'b1;
					smp_if.data <= adc_queue.pop_front();
				end else begin
					smp_if.valid <= 1'b0;
				end
			end
		end
	end

	// reading monitor
	always @(posedge clk or negedge arst_n) begin
		reading_t r;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				readings_seen++;
				if (reading_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected reading %h", res_if.data);
				end else begin
					r = reading_queue.pop_front();
					if (res_if.data[19:1] !== r.temp || res_if.data[0] !== r.level) begin
						mismatches++;
						if (mismatches <= 10)
							$display("reading mismatch: exp temp %0d level %0d, got temp %0d level %0d",
								r.temp, r.level, $signed(res_if.data[19:1]), res_if.data[0]);
					end
				end
			end
			res_if.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (!arst_n || settling || (smp_if.valid && smp_if.ready) ||
				(res_if.valid && res_if.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_MAX) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [18:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		case (idx)
			REG_BETA:     beta_q = value[12:0];
			REG_SETPOINT: setpoint_q = $signed(value);
			REG_BAND:     band_q = value[13:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(int unsigned b, int sp, int unsigned band);
		write_reg(REG_BETA, b[18:0]);
		write_reg(REG_SETPOINT, sp[18:0]);
		write_reg(REG_BAND, band[18:0]);
	endtask

	// wait until every reading is in and the block has settled
	task automatic drain();
		while (adc_queue.size() > 0 || smp_if.valid || reading_queue.size() > 0)
			@(negedge clk);
		settling = 1'b1;
		repeat (SETTLE) @(negedge clk);
		settling = 1'b0;
	endtask

	function automatic logic [11:0] random_adc();
		case ($urandom_range(9))
			0:       return 12'($urandom_range(15));
			1:       return 12'(4095 - $urandom_range(15));
			2, 3:    return 12'(1500 + $urandom_range(1100));
			default: return 12'($urandom_range(4095));
		endcase
	endfunction

	initial begin
		logic [11:0] directed[$];
		int          base;
		int          sp;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		smp_if.valid = 1'b0;
		smp_if.data = '0;
		res_if.ready = 1'b0;
		beta_q = 3950;
		setpoint_q = 4000;
		band_q = 200;
		count_q = 0;
		sum_q = 0;
		level_q = 1'b0;
		idle_pct = 37;
		mismatches = 0;
		readings_seen = 0;
		samples_sent = 0;
		stall_cycles = 0;
		settling = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes and mid-scale with reset values
		directed = '{12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2048, 12'd2047, 12'd2049,
			12'd100, 12'd4000, 12'd3000, 12'd1000, 12'd0, 12'd0, 12'd0, 12'd0,
			12'd2, 12'd4093, 12'd3500, 12'd3900, 12'd3990};
		@(negedge clk);
		foreach (directed[i])
			adc_queue.push_back(directed[i]);
		drain();

		// zero beta, tiny beta where the denominator goes negative, widest beta
		set_regs(0, -27315, 0);
		@(negedge clk);
		for (int i = 0; i < 10; i++)
			adc_queue.push_back(12'(i * 450 + 1));
		drain();
		set_regs(1, 150000, 16383);
		@(negedge clk);
		for (int i = 0; i < 10; i++)
			adc_queue.push_back(12'(4095 - i * 400));
		drain();
		set_regs(8191, 0, 10000);
		@(negedge clk);
		for (int i = 0; i < 10; i++)
			adc_queue.push_back(12'(i * 409));
		drain();

		// random phases with fresh register settings
		for (int p = 0; p < 16; p++) begin
			idle_pct = (p == 5 || p == 6) ? 0 : 37;
			case (p % 4)
				0: set_regs(3000 + $urandom_range(3000), $urandom_range(9000) - 1000,
					$urandom_range(1000));
				1: set_regs($urandom_range(8191), $urandom_range(177315) - 27315,
					$urandom_range(16383));
				2: set_regs((p & 8) ? 3000 : 6000, (p & 8) ? -27315 : 150000,
					(p & 8) ? 0 : 10000);
				default: set_regs(3950, 2000 + $urandom_range(4000), $urandom_range(400));
			endcase
			// keep the mean wandering around the setpoint to toggle the level
			base = $urandom_range(4095);
			@(negedge clk);
			for (int i = 0; i < 95; i++) begin
				if ($urandom_range(3) == 0)
					adc_queue.push_back(random_adc());
				else begin
					sp = base + int'($urandom_range(600)) - 300;
					if (sp < 0) sp = 0;
					if (sp > 4095) sp = 4095;
					adc_queue.push_back(sp[11:0]);
					if ($urandom_range(9) == 0) base = $urandom_range(4095);
				end
			end
			drain();
		end

		$display("run covered %0d samples and %0d readings over 20 register settings",
			samples_sent, readings_seen);
		if (mismatches == 0 && reading_queue.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d mismatches, %0d readings missing", mismatches, reading_queue.size());
			$display("testbench failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/ntc_pkg.sv
design/ntc_stream_if.sv
design/ntc_thermostat.sv
tb/testbench.sv
